// ===== rtl/bwsg_pkg.sv =====
// Package for the basic waveform sample generator.
// Holds widths, wave shape codes, CORDIC constants and shared structs.
// No dependencies.
package bwsg_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 16;
    localparam int PH_W          = 32;
    localparam int CW            = 64;
    localparam int DIV_STAGES    = PH_W;
    localparam int RND_SHIFT     = 41 - SAMPLE_BITS;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic [1:0] FUNC_SINE     = 2'd0;
    localparam logic [1:0] FUNC_SQUARE   = 2'd1;
    localparam logic [1:0] FUNC_TRIANGLE = 2'd2;
    localparam logic [1:0] FUNC_SAWTOOTH = 2'd3;

    localparam logic [2:0] OP_ZERO  = 3'd0;
    localparam logic [2:0] OP_POS   = 3'd1;
    localparam logic [2:0] OP_NEG   = 3'd2;
    localparam logic [2:0] OP_RATIO = 3'd3;
    localparam logic [2:0] OP_SINE  = 3'd4;

    localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
    localparam logic [63:0] GAIN_Q40 = 64'd667681666150;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Classified transaction passed from front to back through the queue.
    typedef struct packed {
        logic [2:0]               op;
        logic                     oor;
        logic signed [IDX_W+2:0]  num;
        logic [IDX_W-1:0]         idx;
        logic [IDX_W-1:0]         len;
    } cmd_t;

    // Long division, evaluated only at elaboration for the arctangent table.
    function automatic logic [CW-1:0] udiv_const(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] d);
        logic [CW-1:0] q;
        logic [CW-1:0] r;
        int            b;
        q = '0;
        r = '0;
        for (b = CW - 1; b >= 0; b--) begin
            r = {r[CW-2:0], a[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [CW-1:0] atan_q60(input int k);
        logic signed [CW-1:0] sum;
        logic [CW-1:0]        term;
        int                   m;
        sum = '0;
        if (k == 0) begin
            sum = $signed(PI_Q62 >> 4);
        end else begin
            for (m = 0; m < 31; m++) begin
                if (k * (2 * m + 1) <= 60) begin
                    term = udiv_const(64'd1 << (60 - k * (2 * m + 1)), CW'(2 * m + 1));
                    if (m[0]) sum = sum - $signed(term);
                    else      sum = sum + $signed(term);
                end
            end
        end
        return sum;
    endfunction

endpackage

// ===== rtl/bwsg_front.sv =====
// Front end: accepts transactions, classifies by shape and range.
// Depends on bwsg_pkg.
module bwsg_front (
    input  logic [1:0]                  func,
    input  logic [bwsg_pkg::IDX_W-1:0]  sample_index,
    input  logic [bwsg_pkg::IDX_W-1:0]  table_length,
    output bwsg_pkg::cmd_t              cmd
);
    import bwsg_pkg::*;

    logic [IDX_W:0]           i2;
    logic [IDX_W+2:0]         i4, n3, n2;
    logic                     lower;

    assign i2    = {sample_index, 1'b0};
    assign i4    = {1'b0, sample_index, 2'b00};
    assign n2    = {2'b00, table_length, 1'b0};
    assign n3    = {3'b000, table_length} + n2;
    assign lower = i2 < {1'b0, table_length};

    always_comb begin
        cmd.idx = sample_index;
        cmd.len = table_length;
        cmd.oor = sample_index >= table_length;
        cmd.num = '0;
        cmd.op  = OP_ZERO;
        if (!cmd.oor) begin
            case (func)
                FUNC_SINE: begin
                    cmd.op = OP_SINE;
                end
                FUNC_SQUARE: begin
                    cmd.op = (sample_index < (table_length >> 1)) ? OP_POS : OP_NEG;
                end
                FUNC_TRIANGLE: begin
                    cmd.op  = OP_RATIO;
                    cmd.num = lower ? $signed(i4 - {3'b000, table_length})
                                    : $signed(n3 - i4);
                end
                default: begin
                    cmd.op  = OP_RATIO;
                    cmd.num = lower ? $signed({2'b00, i2}) : $signed({2'b00, i2} - n2);
                end
            endcase
        end
    end
endmodule

// ===== rtl/bwsg_queue.sv =====
// Short FIFO between front and back ends.
// Depends on bwsg_pkg.
module bwsg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  bwsg_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output bwsg_pkg::cmd_t rd_data
);
    import bwsg_pkg::*;

    cmd_t           mem_reg [Q_DEPTH];
    logic [Q_AW:0]  wp_reg, rp_reg;

    assign wr_ready = (wp_reg - rp_reg) != Q_DEPTH[Q_AW:0];
    assign rd_valid = wp_reg != rp_reg;
    assign rd_data  = mem_reg[rp_reg[Q_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) mem_reg[wp_reg[Q_AW-1:0]] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 1'b1;
        end
    end
endmodule

// ===== rtl/bwsg_back.sv =====
// Back end: pipelined restoring divider, CORDIC and output rounding.
// Stall-as-a-whole pipeline with a skid-free output register. Depends on bwsg_pkg.
module bwsg_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bwsg_pkg::cmd_t                      in_cmd,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bwsg_pkg::SAMPLE_BITS-1:0] out_sample,
    output logic                                out_oor
);
    import bwsg_pkg::*;

    localparam int F    = SAMPLE_BITS - 1;
    localparam int DW   = IDX_W + F + 4;   // ratio dividend magnitude bits
    localparam int NST  = DIV_STAGES + CORDIC_STAGES + 1;
    localparam int RW   = IDX_W + 2;

    // Shared pipeline enable: the whole pipe moves when output slot frees.
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Division stages: a 32-step restoring divide. For sine the dividend is
    // idx*2^32, for ratio the dividend magnitude (padded) is shifted in.
    logic              v_reg   [NST+1];
    logic [2:0]        op_reg  [NST+1];
    logic              oor_reg [NST+1];
    logic [RW-1:0]     rem_reg [DIV_STAGES+1];
    logic [PH_W-1:0]   quo_reg [DIV_STAGES+1];
    logic [PH_W-1:0]   dvd_reg [DIV_STAGES+1];
    logic [RW-1:0]     den_reg [DIV_STAGES+1];
    logic              neg_reg [DIV_STAGES+1];

    logic signed [CW-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES+1];
    logic [1:0]           qd_reg [CORDIC_STAGES+1];
    logic signed [PH_W:0] rq_reg [CORDIC_STAGES+1];

    // Stage 0 load.
    logic [DW-1:0]  mag;
    logic [RW-1:0]  den_in;
    logic [PH_W-1:0] dvd_in;
    logic [RW-1:0]  rem_in;
    logic signed [DW:0] a_s;
    always_comb begin
        a_s    = ($signed({{(DW-IDX_W-2){in_cmd.num[IDX_W+2]}}, in_cmd.num}) <<< (F + 1))
                 + $signed({{(DW-IDX_W+1){1'b0}}, in_cmd.len});
        mag    = a_s[DW] ? DW'(-a_s) : a_s[DW-1:0];
        if (in_cmd.op == OP_SINE) begin
            den_in = {2'b00, in_cmd.len};
            rem_in = {2'b00, in_cmd.idx};
            dvd_in = '0;
        end else begin
            den_in = {1'b0, in_cmd.len, 1'b0};
            rem_in = '0;
            dvd_in = PH_W'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg[0]  <= in_cmd.op;
            oor_reg[0] <= in_cmd.oor;
            rem_reg[0] <= rem_in;
            quo_reg[0] <= '0;
            dvd_reg[0] <= dvd_in;
            den_reg[0] <= den_in;
            neg_reg[0] <= a_s[DW];
        end
        if (!aresetn) v_reg[0] <= 1'b0;
        else if (adv) v_reg[0] <= in_valid;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [RW:0] trial;
        logic [RW:0] diff;
        assign trial = {rem_reg[k], dvd_reg[k][PH_W-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                op_reg[k+1]  <= op_reg[k];
                oor_reg[k+1] <= oor_reg[k];
                dvd_reg[k+1] <= {dvd_reg[k][PH_W-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                if (!diff[RW]) begin
                    rem_reg[k+1] <= diff[RW-1:0];
                    quo_reg[k+1] <= {quo_reg[k][PH_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= trial[RW-1:0];
                    quo_reg[k+1] <= {quo_reg[k][PH_W-2:0], 1'b0};
                end
            end
            if (!aresetn) v_reg[k+1] <= 1'b0;
            else if (adv) v_reg[k+1] <= v_reg[k];
        end
    end

    // Angle conversion stage: r*H>>1 + r*L>>33, split in two 32x32 products.
    localparam int S0 = DIV_STAGES;
    logic [PH_W-1:0] p_s;
    logic [29:0]     r_s;
    logic [63:0]     ph_hi, ph_lo;
    logic signed [PH_W:0] rq_in;
    assign p_s   = quo_reg[S0];
    assign r_s   = p_s[29:0];
    assign ph_hi = {34'd0, r_s} * {32'd0, PI_Q62[63:32]};
    assign ph_lo = {34'd0, r_s} * {32'd0, PI_Q62[31:0]};
    // Ratio quotient: floor of signed value; negative uses ceil of magnitude.
    assign rq_in = neg_reg[S0]
        ? -$signed({1'b0, quo_reg[S0]} + {{PH_W{1'b0}}, (rem_reg[S0] != '0)})
        : $signed({1'b0, quo_reg[S0]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg[S0+1]  <= op_reg[S0];
            oor_reg[S0+1] <= oor_reg[S0];
            x_reg[0]      <= $signed(GAIN_Q40);
            y_reg[0]      <= '0;
            z_reg[0]      <= $signed((ph_hi >> 1) + (ph_lo >> 33));
            qd_reg[0]     <= p_s[31:30];
            rq_reg[0]     <= rq_in;
        end
        if (!aresetn) v_reg[S0+1] <= 1'b0;
        else if (adv) v_reg[S0+1] <= v_reg[S0];
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
        localparam logic signed [CW-1:0] ATAN = atan_q60(k);
        logic signed [CW-1:0] dx, dy;
        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        always_ff @(posedge aclk) begin
            if (adv) begin
                op_reg[S0+k+2]  <= op_reg[S0+k+1];
                oor_reg[S0+k+2] <= oor_reg[S0+k+1];
                qd_reg[k+1]     <= qd_reg[k];
                rq_reg[k+1]     <= rq_reg[k];
                if (!z_reg[k][CW-1]) begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - ATAN;
                end else begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + ATAN;
                end
            end
            if (!aresetn) v_reg[S0+k+2] <= 1'b0;
            else if (adv) v_reg[S0+k+2] <= v_reg[S0+k+1];
        end
    end

    // Final stage: quadrant select, rounding, saturation, output register.
    localparam int SL = S0 + CORDIC_STAGES + 1;
    logic signed [CW-1:0]          sv, rv;
    logic signed [SAMPLE_BITS-1:0] res;
    always_comb begin
        case (qd_reg[CORDIC_STAGES])
            2'd0:    sv = y_reg[CORDIC_STAGES];
            2'd1:    sv = x_reg[CORDIC_STAGES];
            2'd2:    sv = -y_reg[CORDIC_STAGES];
            default: sv = -x_reg[CORDIC_STAGES];
        endcase
        rv = (sv + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        case (op_reg[SL])
            OP_POS:  res = S_MAX;
            OP_NEG:  res = S_MIN;
            OP_SINE: begin
                if (rv > CW'(S_MAX))      res = S_MAX;
                else if (rv < CW'(S_MIN)) res = S_MIN;
                else                      res = rv[SAMPLE_BITS-1:0];
            end
            OP_RATIO: begin
                if (rq_reg[CORDIC_STAGES] > (PH_W+1)'(S_MAX))      res = S_MAX;
                else if (rq_reg[CORDIC_STAGES] < (PH_W+1)'(S_MIN)) res = S_MIN;
                else res = rq_reg[CORDIC_STAGES][SAMPLE_BITS-1:0];
            end
            default: res = '0;
        endcase
    end

    logic                          ov_reg;
    logic signed [SAMPLE_BITS-1:0] os_reg;
    logic                          oo_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            os_reg <= res;
            oo_reg <= oor_reg[SL];
        end
        if (!aresetn) ov_reg <= 1'b0;
        else if (adv) ov_reg <= v_reg[SL];
    end
    assign out_valid  = ov_reg;
    assign out_sample = os_reg;
    assign out_oor    = oo_reg;
endmodule

// ===== rtl/basic_waveform_sample_generator_unit.sv =====
// Channel   Ports                                   Direction
// input     s_valid s_ready s_func s_sample_index   in
// result    m_valid m_ready m_sample_value m_index_out_of_range  out
// config    APB psel penable pwrite paddr pwdata    in
// One transaction per clock sustained while the result channel is not stalled,
// through the 32-step pipelined divider and 16-stage CORDIC back end.
// Synchronous active-low reset empties queue and pipeline, length to 1024.
// Result stall freezes the back pipeline; the queue absorbs front traffic.
// Top level. Depends on bwsg_pkg, bwsg_front, bwsg_queue, bwsg_back.
module basic_waveform_sample_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_sample_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_sample_value,
    output logic        m_index_out_of_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bwsg_pkg::*;

    logic [IDX_W-1:0] len_reg;
    cmd_t             f_cmd, q_cmd;
    logic             q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = paddr ? 32'd0 : {16'd0, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= 16'd1024;
        end else if (psel && penable && pwrite && !paddr) begin
            len_reg <= pwdata[15:0];
        end
    end

    bwsg_front u_front (
        .func(s_func), .sample_index(s_sample_index),
        .table_length(len_reg), .cmd(f_cmd)
    );

    bwsg_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    bwsg_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_cmd),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_sample(m_sample_value), .out_oor(m_index_out_of_range)
    );

`ifndef SYNTH
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_out_of_range |-> m_sample_value == 16'sd0)
        else $error("out of range result not zero");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_value))
        else $error("stalled result changed");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        !(psel && penable && pwrite) |=> $stable(len_reg))
        else $error("length changed without write");
`endif
endmodule

// ===== dv/tb.sv =====
// Testbench for basic_waveform_sample_generator_unit: sine, square, triangle and
// sawtooth samples checked against a bit-accurate predictor across table lengths.
// Depends on bwsg_pkg and the RTL of the unit.
module tb;
    import bwsg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_SINE;
    logic [15:0] s_sample_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [15:0] m_sample_value;
    logic        m_index_out_of_range;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic        paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam logic ADDR_TABLE_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [15:0] value;
        logic               oor;
    } sample_t;

    sample_t     sample_q[$];
    logic [15:0] cur_len = 16'd1024;
    int          errors = 0;
    int          rx_hold = 0;
    bit          rx_calm = 1'b0;
    bit          tx_calm = 1'b0;

    basic_waveform_sample_generator_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [63:0] fshr(input logic signed [63:0] v, input int k);
        return v >>> k;
    endfunction

    function automatic logic signed [63:0] fdiv(input logic signed [63:0] a,
                                                 input logic signed [63:0] d);
        if (a >= 0) return a / d;
        return -((-a + d - 1) / d);
    endfunction

    function automatic logic signed [63:0] clamp16(input logic signed [63:0] v);
        if (v > 64'sd32767) return 64'sd32767;
        if (v < -64'sd32768) return -64'sd32768;
        return v;
    endfunction

    function automatic logic signed [63:0] arctan_step(input int k);
        logic signed [63:0] acc;
        int m;
        acc = 0;
        if (k == 0) return $signed(PI_Q62 >> 4);
        for (m = 0; k * (2 * m + 1) <= 60; m++) begin
            if (m % 2 == 1) acc = acc - $signed((64'd1 << (60 - k * (2 * m + 1))) / (2 * m + 1));
            else            acc = acc + $signed((64'd1 << (60 - k * (2 * m + 1))) / (2 * m + 1));
        end
        return acc;
    endfunction

    function automatic logic signed [63:0] sine_q40(input logic [31:0] p);
        logic [63:0]        r, hi, lo;
        logic signed [63:0] x, y, z, dx, dy;
        int k;
        r  = {34'd0, p[29:0]};
        hi = PI_Q62 >> 32;
        lo = {32'd0, PI_Q62[31:0]};
        z  = $signed(((r * hi) >> 1) + ((r * lo) >> 33));
        x  = $signed(GAIN_Q40);
        y  = 0;
        for (k = 0; k < CORDIC_STAGES; k++) begin
            dx = fshr(y, k);
            dy = fshr(x, k);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - arctan_step(k);
            end else begin
                x = x + dx; y = y - dy; z = z + arctan_step(k);
            end
        end
        case (p[31:30])
            2'd0: return y;
            2'd1: return x;
            2'd2: return -y;
            default: return -x;
        endcase
    endfunction

    function automatic logic signed [63:0] ratio(input logic signed [63:0] num,
                                                 input logic signed [63:0] n);
        return clamp16(fdiv(2 * num * 64'sd32768 + n, 2 * n));
    endfunction

    function automatic sample_t waveform_sample(input logic [1:0] f, input logic [15:0] idx);
        sample_t            s;
        logic signed [63:0] i, n, v;
        logic [31:0]        p;
        i = {48'd0, idx};
        n = {48'd0, cur_len};
        s.oor = 1'b0;
        if (i >= n) begin
            s.value = '0;
            s.oor = 1'b1;
            return s;
        end
        case (f)
            FUNC_SINE: begin
                p = 32'(({48'd0, idx} << 32) / {48'd0, cur_len});
                v = clamp16(fshr(sine_q40(p) + (64'sd1 << 24), 25));
            end
            FUNC_SQUARE: v = (i < n / 2) ? 64'sd32767 : -64'sd32768;
            FUNC_TRIANGLE: v = (2 * i < n) ? ratio(4 * i - n, n) : ratio(3 * n - 4 * i, n);
            default: v = (2 * i < n) ? ratio(2 * i, n) : ratio(2 * i - 2 * n, n);
        endcase
        s.value = v[15:0];
        return s;
    endfunction

    task automatic idle_gap(input bit calm);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic send_sample(input logic [1:0] f, input logic [15:0] idx);
        idle_gap(tx_calm);
        sample_q.push_back(waveform_sample(f, idx));
        s_valid <= 1'b1;
        s_func <= f;
        s_sample_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sample_q.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_length(input logic [15:0] len);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_TABLE_LENGTH; pwdata <= {16'hA5A5, len};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cur_len = len;
    endtask

    always @(posedge aclk) begin
        sample_t e;
        if (m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                $error("unexpected transaction: value %0d flag %0b",
                       m_sample_value, m_index_out_of_range);
                errors++;
            end else begin
                e = sample_q.pop_front();
                if (m_sample_value !== e.value) begin
                    $error("sample_value expected %0d actual %0d", e.value, m_sample_value);
                    errors++;
                end
                if (m_index_out_of_range !== e.oor) begin
                    $error("index_out_of_range expected %0b actual %0b",
                           e.oor, m_index_out_of_range);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || rx_calm) begin
            m_ready <= 1'b1;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            if (rx_hold == 0) m_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            rx_hold = $urandom_range(1, 12);
        end
    end

    task automatic test_reset_length();
        send_sample(FUNC_SINE, 16'd0);
        send_sample(FUNC_SINE, 16'd256);
        send_sample(FUNC_SQUARE, 16'd1023);
        send_sample(FUNC_TRIANGLE, 16'd1024);
        send_sample(FUNC_SAWTOOTH, 16'hFFFF);
    endtask

    task automatic test_shapes_directed();
        int f;
        write_length(16'd8);
        for (f = 0; f < 4; f++) begin
            send_sample(f[1:0], 16'd0);
            send_sample(f[1:0], 16'd3);
            send_sample(f[1:0], 16'd4);
            send_sample(f[1:0], 16'd7);
        end
        write_length(16'd7);
        send_sample(FUNC_SQUARE, 16'd3);
        send_sample(FUNC_TRIANGLE, 16'd6);
        send_sample(FUNC_SAWTOOTH, 16'd7);
    endtask

    task automatic test_length_extremes();
        write_length(16'd2);
        send_sample(FUNC_SINE, 16'd1);
        send_sample(FUNC_SAWTOOTH, 16'd1);
        write_length(16'hFFFF);
        send_sample(FUNC_SINE, 16'hFFFE);
        send_sample(FUNC_TRIANGLE, 16'hFFFF);
        write_length(16'd1);
        send_sample(FUNC_SINE, 16'd0);
        send_sample(FUNC_SQUARE, 16'd0);
        write_length(16'd0);
        send_sample(FUNC_SAWTOOTH, 16'd0);
    endtask

    task automatic test_random_phases();
        int ph, k;
        logic [15:0] idx;
        for (ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: write_length(16'($urandom_range(2, 64)));
                1: write_length(16'($urandom_range(2, 65535)));
                2: write_length(16'hFFFF);
                default: write_length(16'($urandom_range(2, 4096)));
            endcase
            if (ph >= 8) begin
                tx_calm = 1'b1;
                rx_calm = 1'b1;
            end
            for (k = 0; k < 100; k++) begin
                if ($urandom_range(0, 9) == 0) idx = 16'($urandom);
                else idx = 16'($urandom_range(0, cur_len - 1));
                send_sample(2'($urandom_range(0, 3)), idx);
                if (ph == 3 && k == 50) drain();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_length();
        test_shapes_directed();
        test_length_extremes();
        test_random_phases();
        drain();
        if (errors == 0 && sample_q.size() == 0) begin
            $display("** basic_waveform_sample_generator_unit: PASSED **");
        end else begin
            $display("** basic_waveform_sample_generator_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** basic_waveform_sample_generator_unit: FAILED **");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bwsg_pkg.sv
rtl/bwsg_front.sv
rtl/bwsg_queue.sv
rtl/bwsg_back.sv
rtl/basic_waveform_sample_generator_unit.sv
dv/tb.sv
